// ===== src/bst_pkg.sv =====
// Shared types and constants for the byte stream tokenizer.
package bst_pkg;

  // Token kinds; KIND_END also marks "nothing pending" in the back end.
  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_BLANK   = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_INTEGER = 3'd3,
    KIND_NUMBER  = 3'd4,
    KIND_IDENT   = 3'd5,
    KIND_SINGLE  = 3'd6
  } kind_t;

  // Byte classes worked out in the front end.
  typedef enum logic [3:0] {
    CLS_BLANK,
    CLS_CR,
    CLS_LF,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_DOT,
    CLS_UNDERSCORE,
    CLS_IDENT_START,
    CLS_OTHER,
    CLS_END
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data_byte;
  } q_entry_t;

  localparam logic       OP_DATA         = 1'b0;
  localparam logic       OP_END          = 1'b1;

  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] HIGH_BYTE_LIMIT = 8'd127;
  localparam logic [7:0] CHAR_NONE       = 8'h00;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TOKEN_FILTER = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_LINE   = 2'd1;

  localparam int QUEUE_DEPTH  = 2;
  localparam int RESULT_DEPTH = 4;

endpackage

// ===== src/bst_in_if.sv =====
// Input word channel: operation and source byte.
interface bst_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, op, data_byte, input ready);
  modport sink   (input valid, op, data_byte, output ready);
endinterface

// ===== src/bst_out_if.sv =====
// Result word channel: one token record per word.
interface bst_out_if #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16,
  parameter int OFFSET_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [7:0]             char_code;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_column;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   is_end;

  modport source (output valid, token_kind, char_code, start_line, start_column,
                  start_offset, token_length, is_end, input ready);
  modport sink   (input valid, token_kind, char_code, start_line, start_column,
                  start_offset, token_length, is_end, output ready);
endinterface

// ===== src/bst_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface bst_cfg_if
  import bst_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bst_fifo.sv =====
// Small queue taking up to two words per cycle and giving one.
module bst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  logic [WIDTH-1:0] push_a,
  input  logic [WIDTH-1:0] push_b,
  output logic             room_one,
  output logic             room_two,
  output logic             head_valid,
  output logic [WIDTH-1:0] head,
  input  logic             pop
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [PTR_BITS-1:0] wr_ptr_b;

  function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign wr_ptr_b   = wrap_inc(wr_ptr_r);
  assign room_one   = (count_r < CNT_BITS'(DEPTH));
  assign room_two   = (count_r <= CNT_BITS'(DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_cnt == 2'd1) begin
      wr_ptr_nxt = wr_ptr_b;
    end else if (push_cnt == 2'd2) begin
      wr_ptr_nxt = wrap_inc(wr_ptr_b);
    end
    if (pop) begin
      rd_ptr_nxt = wrap_inc(rd_ptr_r);
    end
    count_nxt = count_r + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/bst_front.sv =====
// Front end: accept input words and classify each byte for the back end.
module bst_front
  import bst_pkg::*;
(
  bst_in_if.sink   in_ch,
  input  logic     q_room_one,
  output logic [1:0] q_push_cnt,
  output q_entry_t q_entry
);

  cls_t cls;

  always_comb begin
    if (in_ch.op == OP_END) begin
      cls = CLS_END;
    end else begin
      case (in_ch.data_byte) inside
        CHAR_SPACE, CHAR_TAB:             cls = CLS_BLANK;
        CHAR_CR:                          cls = CLS_CR;
        CHAR_LF:                          cls = CLS_LF;
        [8'h30:8'h39]:                    cls = CLS_DIGIT;
        CHAR_MINUS:                       cls = CLS_MINUS;
        CHAR_DOT:                         cls = CLS_DOT;
        CHAR_UNDERSCORE:                  cls = CLS_UNDERSCORE;
        [8'h41:8'h5A], [8'h61:8'h7A]:     cls = CLS_IDENT_START;
        default: begin
          // high bytes open identifiers as letters do
          cls = (in_ch.data_byte > HIGH_BYTE_LIMIT) ? CLS_IDENT_START : CLS_OTHER;
        end
      endcase
    end
  end

  assign in_ch.ready       = q_room_one;
  assign q_push_cnt        = {1'b0, in_ch.valid & q_room_one};
  assign q_entry.cls       = cls;
  assign q_entry.data_byte = in_ch.data_byte;

endmodule

// ===== src/bst_back.sv =====
// Back end: token state, position counters and result records.
module bst_back
  import bst_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  bst_cfg_if.sink  cfg_ch,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  input  logic     res_room_two,
  output logic [1:0] res_push_cnt,
  output logic [3+8+LINE_BITS+COLUMN_BITS+OFFSET_BITS+LENGTH_BITS:0] res_push_a,
  output logic [3+8+LINE_BITS+COLUMN_BITS+OFFSET_BITS+LENGTH_BITS:0] res_push_b
);

  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  logic [1:0]             filter_r;
  logic                   first_line_r;
  kind_t                  pend_kind_r, pend_kind_nxt;
  logic                   pend_cr_r, pend_cr_nxt;
  logic                   pend_minus_r, pend_minus_nxt;
  logic [LINE_BITS-1:0]   tok_line_r, tok_line_nxt;
  logic [COLUMN_BITS-1:0] tok_col_r, tok_col_nxt;
  logic [OFFSET_BITS-1:0] tok_off_r, tok_off_nxt;
  logic [LENGTH_BITS-1:0] tok_len_r, tok_len_nxt;
  logic [LINE_BITS-1:0]   cur_line_r, cur_line_nxt;
  logic [COLUMN_BITS-1:0] cur_col_r, cur_col_nxt;
  logic [OFFSET_BITS-1:0] cur_off_r, cur_off_nxt;

  logic                   take;
  logic                   ext;
  logic                   flush_ok;
  logic                   f_emit, n_emit;
  logic [LENGTH_BITS-1:0] f_len, len_grown;
  kind_t                  n_kind;
  logic [7:0]             n_char;
  logic [LENGTH_BITS-1:0] n_len;
  logic                   n_is_end;
  logic [COLUMN_BITS-1:0] col_adv;
  logic [OFFSET_BITS-1:0] off_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LINE_BITS-1:0]   first_line_ext;
  logic [3+8+LINE_BITS+COLUMN_BITS+OFFSET_BITS+LENGTH_BITS:0] f_rec, n_rec;
  cls_t                   cls;
  logic                   ident_cont;

  assign cls            = q_head.cls;
  assign take           = q_valid & res_room_two;
  assign q_pop          = take;
  // hold off register writes while a word is being taken
  assign cfg_ch.ready   = ~take;
  assign ident_cont     = (cls == CLS_IDENT_START) || (cls == CLS_DIGIT) ||
                          (cls == CLS_UNDERSCORE);
  assign len_grown      = (tok_len_r == LEN_MAX) ? tok_len_r : tok_len_r + 1'b1;
  assign col_adv        = (cur_col_r == COL_MAX) ? cur_col_r : cur_col_r + 1'b1;
  assign off_inc        = cur_off_r + 1'b1;
  assign line_inc       = cur_line_r + 1'b1;
  assign first_line_ext = LINE_BITS'(first_line_r);

  always_comb begin
    if (pend_minus_r) begin
      flush_ok = 1'b1;
    end else begin
      case (pend_kind_r)
        KIND_END:     flush_ok = 1'b0;
        KIND_BLANK:   flush_ok = filter_r[0];
        KIND_NEWLINE: flush_ok = filter_r[1];
        default:      flush_ok = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (pend_minus_r) begin
      ext = (cls == CLS_DIGIT);
    end else if (pend_cr_r) begin
      ext = (cls == CLS_LF);
    end else begin
      case (pend_kind_r)
        KIND_BLANK:   ext = (cls == CLS_BLANK);
        KIND_INTEGER: ext = (cls == CLS_DIGIT) || (cls == CLS_DOT);
        KIND_NUMBER:  ext = (cls == CLS_DIGIT);
        KIND_IDENT:   ext = ident_cont;
        default:      ext = 1'b0;
      endcase
    end
  end

  always_comb begin
    pend_kind_nxt  = pend_kind_r;
    pend_cr_nxt    = pend_cr_r;
    pend_minus_nxt = pend_minus_r;
    tok_line_nxt   = tok_line_r;
    tok_col_nxt    = tok_col_r;
    tok_off_nxt    = tok_off_r;
    tok_len_nxt    = tok_len_r;
    cur_line_nxt   = cur_line_r;
    cur_col_nxt    = cur_col_r;
    cur_off_nxt    = cur_off_r;
    f_emit         = 1'b0;
    f_len          = tok_len_r;
    n_emit         = 1'b0;
    n_kind         = KIND_SINGLE;
    n_char         = CHAR_NONE;
    n_len          = LEN_ONE;
    n_is_end       = 1'b0;

    if (cls == CLS_END) begin
      // flush, then the end word at the current position; restart the stream
      f_emit         = flush_ok;
      pend_kind_nxt  = KIND_END;
      pend_cr_nxt    = 1'b0;
      pend_minus_nxt = 1'b0;
      n_emit         = 1'b1;
      n_kind         = KIND_END;
      n_len          = '0;
      n_is_end       = 1'b1;
      cur_line_nxt   = first_line_ext;
      cur_col_nxt    = '0;
      cur_off_nxt    = '0;
    end else if (ext) begin
      tok_len_nxt = len_grown;
      if (pend_cr_r) begin
        // CR LF closes as one newline; the LF moves the offset only
        f_emit        = filter_r[1];
        f_len         = len_grown;
        pend_kind_nxt = KIND_END;
        pend_cr_nxt   = 1'b0;
        cur_off_nxt   = off_inc;
      end else begin
        cur_col_nxt = col_adv;
        cur_off_nxt = off_inc;
        if (pend_minus_r) begin
          pend_minus_nxt = 1'b0;
          pend_kind_nxt  = KIND_INTEGER;
        end else if (pend_kind_r == KIND_INTEGER && cls == CLS_DOT) begin
          pend_kind_nxt = KIND_NUMBER;
        end
      end
    end else begin
      f_emit         = flush_ok;
      pend_kind_nxt  = KIND_END;
      pend_cr_nxt    = 1'b0;
      pend_minus_nxt = 1'b0;
      tok_line_nxt   = cur_line_r;
      tok_col_nxt    = cur_col_r;
      tok_off_nxt    = cur_off_r;
      tok_len_nxt    = LEN_ONE;
      cur_col_nxt    = col_adv;
      cur_off_nxt    = off_inc;
      case (cls)
        CLS_BLANK: begin
          pend_kind_nxt = KIND_BLANK;
        end
        CLS_CR: begin
          pend_kind_nxt = KIND_NEWLINE;
          pend_cr_nxt   = 1'b1;
          cur_line_nxt  = line_inc;
          cur_col_nxt   = '0;
        end
        CLS_LF: begin
          n_emit       = filter_r[1];
          n_kind       = KIND_NEWLINE;
          cur_line_nxt = line_inc;
          cur_col_nxt  = '0;
        end
        CLS_DIGIT: begin
          pend_kind_nxt = KIND_INTEGER;
        end
        CLS_MINUS: begin
          pend_minus_nxt = 1'b1;
        end
        CLS_IDENT_START: begin
          pend_kind_nxt = KIND_IDENT;
        end
        default: begin
          n_emit = 1'b1;
          n_char = q_head.data_byte;
        end
      endcase
    end
  end

  always_comb begin
    if (pend_minus_r) begin
      f_rec = {KIND_SINGLE, CHAR_MINUS, tok_line_r, tok_col_r, tok_off_r, LEN_ONE, 1'b0};
    end else begin
      f_rec = {pend_kind_r, CHAR_NONE, tok_line_r, tok_col_r, tok_off_r, f_len, 1'b0};
    end
    n_rec = {n_kind, n_char, cur_line_r, cur_col_r, cur_off_r, n_len, n_is_end};
  end

  // drop filtered records; pack the rest at the head
  assign res_push_cnt = take ? (2'(f_emit) + 2'(n_emit)) : 2'd0;
  assign res_push_a   = f_emit ? f_rec : n_rec;
  assign res_push_b   = n_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r     <= 2'd0;
      first_line_r <= 1'b1;
      pend_kind_r  <= KIND_END;
      pend_cr_r    <= 1'b0;
      pend_minus_r <= 1'b0;
      tok_line_r   <= '0;
      tok_col_r    <= '0;
      tok_off_r    <= '0;
      tok_len_r    <= '0;
      cur_line_r   <= LINE_BITS'(1);
      cur_col_r    <= '0;
      cur_off_r    <= '0;
    end else if (take) begin
      pend_kind_r  <= pend_kind_nxt;
      pend_cr_r    <= pend_cr_nxt;
      pend_minus_r <= pend_minus_nxt;
      tok_line_r   <= tok_line_nxt;
      tok_col_r    <= tok_col_nxt;
      tok_off_r    <= tok_off_nxt;
      tok_len_r    <= tok_len_nxt;
      cur_line_r   <= cur_line_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_off_r    <= cur_off_nxt;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TOKEN_FILTER) begin
        filter_r <= cfg_ch.data[1:0];
      end else if (cfg_ch.index == REG_FIRST_LINE) begin
        first_line_r <= cfg_ch.data[0];
        // load the line counter only at the very start of a stream
        if (cur_off_r == '0 && pend_kind_r == KIND_END && !pend_minus_r) begin
          cur_line_r <= LINE_BITS'(cfg_ch.data[0]);
        end
      end
    end
  end

endmodule

// ===== src/byte_stream_tokenizer.sv =====
// Byte stream tokenizer top level: front end, word queue, back end, result queue.
// Throughput: one byte per cycle while the result queue has room for two records, set by
// the back end's single token-state update; a byte that yields two records pushes both.
// Path: each byte is registered in the word queue, and the back end writes each record
// it closes into the result queue, which drives out_ch; input stalls once the result
// queue lacks room for two records and the two-word queue has filled.
// Reset (rst_n, synchronous) empties both queues, clears the token state and sets
// the line counter to 1; no clearing pass is needed.
module byte_stream_tokenizer
  import bst_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bst_in_if.sink     in_ch,
  bst_out_if.source  out_ch,
  bst_cfg_if.sink    cfg_ch
);

  localparam int REC_BITS = 3 + 8 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + 1;

  logic [1:0]          q_push_cnt;
  q_entry_t            q_entry;
  q_entry_t            q_head;
  logic                q_room_one, q_room_two_unused;
  logic                q_valid, q_pop;

  logic [1:0]          res_push_cnt;
  logic [REC_BITS-1:0] res_push_a, res_push_b, res_head;
  logic                res_room_one_unused, res_room_two;
  logic                res_pop;

  bst_front u_front (
    .in_ch      (in_ch),
    .q_room_one (q_room_one),
    .q_push_cnt (q_push_cnt),
    .q_entry    (q_entry)
  );

  bst_fifo #(
    .WIDTH ($bits(q_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_word_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (q_push_cnt),
    .push_a     (q_entry),
    .push_b     (q_entry),
    .room_one   (q_room_one),
    .room_two   (q_room_two_unused),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  bst_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ch       (cfg_ch),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .res_room_two (res_room_two),
    .res_push_cnt (res_push_cnt),
    .res_push_a   (res_push_a),
    .res_push_b   (res_push_b)
  );

  bst_fifo #(
    .WIDTH (REC_BITS),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (res_push_cnt),
    .push_a     (res_push_a),
    .push_b     (res_push_b),
    .room_one   (res_room_one_unused),
    .room_two   (res_room_two),
    .head_valid (out_ch.valid),
    .head       (res_head),
    .pop        (res_pop)
  );

  assign res_pop = out_ch.valid & out_ch.ready;

  assign {out_ch.token_kind, out_ch.char_code, out_ch.start_line, out_ch.start_column,
          out_ch.start_offset, out_ch.token_length, out_ch.is_end} = res_head;

endmodule
